FILE: rtl/spq_pkg.sv
// shared types, constants and codes of the sorted priority queue
package spq_pkg;

    localparam int unsigned DEPTH   = 16;
    localparam int unsigned OCC_W   = $clog2(DEPTH + 1);
    localparam int unsigned PRIO_W  = 16;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned FILL_W  = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [PRIO_W-1:0]  prio;
        logic signed [VALUE_W-1:0] value;
    } t_entry;

    // broadcast to every cell in the row
    typedef struct packed {
        logic   insert_en;
        logic   remove_en;
        t_entry new_entry;
    } t_cell_ctrl;

endpackage

FILE: rtl/spq_if.sv
// valid/ready channel interfaces for the request and response beats
interface spq_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 opcode;
    logic signed [spq_pkg::PRIO_W-1:0]    entry_priority;
    logic signed [spq_pkg::VALUE_W-1:0]   entry_value;

    modport source (output valid, output opcode, output entry_priority,
                    output entry_value, input ready);
    modport sink   (input valid, input opcode, input entry_priority,
                    input entry_value, output ready);
endinterface

interface spq_out_if;
    logic                                 valid;
    logic                                 ready;
    logic        [1:0]                    status;
    logic signed [spq_pkg::VALUE_W-1:0]   served_value;
    logic signed [spq_pkg::PRIO_W-1:0]    served_priority;
    logic        [spq_pkg::FILL_W-1:0]    fill_level;

    modport source (output valid, output status, output served_value,
                    output served_priority, output fill_level, input ready);
    modport sink   (input valid, input status, input served_value,
                    input served_priority, input fill_level, output ready);
endinterface

FILE: rtl/spq_cell.sv
// one compare-and-shift cell of the sorted row
module spq_cell (
    input  logic                i_clk,
    input  spq_pkg::t_cell_ctrl i_ctrl,
    input  logic                i_occupied,
    input  logic                i_left_flag,
    input  spq_pkg::t_entry     i_left_entry,
    input  spq_pkg::t_entry     i_right_entry,
    output logic                o_flag,
    output spq_pkg::t_entry     o_entry
);
    import spq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // set where the new entry belongs at or ahead of this cell
    assign o_flag  = !i_occupied ||
                     ($signed(r_entry.prio) <= $signed(i_ctrl.new_entry.prio));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.insert_en) begin
            if (o_flag && !i_left_flag) begin
                n_entry = i_ctrl.new_entry;
            end else if (o_flag) begin
                n_entry = i_left_entry;
            end
        end else if (i_ctrl.remove_en) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

FILE: rtl/sorted_priority_queue.sv
// sorted priority queue: a row of compare-and-shift cells, highest priority at cell 0
// a result beat is registered and valid in the cycle after its request is accepted
// throughput: one request per cycle unless stalled; cells compare and shift in parallel
// reset: fill count and output valid clear; cell contents stay undefined until written
// a stalled output holds the result and blocks new requests until it is taken
module sorted_priority_queue (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);
    import spq_pkg::*;

    // fill count of the row
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;

    // output register
    logic                     r_out_valid;
    t_status                  r_status;
    logic signed [VALUE_W-1:0] r_value;
    logic signed [PRIO_W-1:0]  r_prio;
    logic [FILL_W-1:0]        r_fill;

    logic       accept;
    logic       is_full;
    logic       is_empty;
    t_status    n_status;
    t_cell_ctrl ctrl;

    logic   [DEPTH-1:0] flags;
    logic   [DEPTH-1:0] occupied;
    t_entry             entries [DEPTH];

    // accept while the output register is empty or draining this cycle
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign is_full  = (r_occ == OCC_W'(DEPTH));
    assign is_empty = (r_occ == '0);

    assign ctrl.insert_en       = accept && (i_in.opcode == OP_INSERT) && !is_full;
    assign ctrl.remove_en       = accept && (i_in.opcode == OP_REMOVE) && !is_empty;
    assign ctrl.new_entry.prio  = i_in.entry_priority;
    assign ctrl.new_entry.value = i_in.entry_value;

    always_comb begin
        n_occ    = r_occ;
        n_status = ST_DONE;
        if (i_in.opcode == OP_INSERT) begin
            if (is_full) begin
                n_status = ST_FULL;
            end else begin
                n_occ = r_occ + OCC_W'(1);
            end
        end else begin
            if (is_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_occ = r_occ - OCC_W'(1);
            end
        end
    end

    // the row: each cell sees its left and right neighbor
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic   left_flag;
        t_entry left_entry;
        t_entry right_entry;

        assign occupied[g] = (r_occ > OCC_W'(g));

        if (g == 0) begin : g_head
            // nothing sits ahead of the head cell
            assign left_flag  = 1'b0;
            assign left_entry = ctrl.new_entry;
        end else begin : g_body
            assign left_flag  = flags[g-1];
            assign left_entry = entries[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            // tail content past the fill count is never read
            assign right_entry = entries[g];
        end else begin : g_inner
            assign right_entry = entries[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (occupied[g]),
            .i_left_flag   (left_flag),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_flag        (flags[g]),
            .o_entry       (entries[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_occ       <= n_occ;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, head cell read before the shift lands
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_fill   <= FILL_W'(n_occ);
            if (ctrl.remove_en) begin
                r_value <= entries[0].value;
                r_prio  <= entries[0].prio;
            end else begin
                r_value <= '0;
                r_prio  <= '0;
            end
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.status          = r_status;
    assign o_out.served_value    = r_value;
    assign o_out.served_priority = r_prio;
    assign o_out.fill_level      = r_fill;

endmodule
